[hdl/integer_to_ascii_radix_unit_defines.svh]
// assertion macros shared by the integer to ascii radix unit
// expects signals named clock and reset in the module that uses them
`ifndef INTEGER_TO_ASCII_RADIX_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ITOA_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("itoa check failed");
// antecedent implies consequent in the next cycle
`define ITOA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("itoa check failed");
`else
`define ITOA_ASSERT_IMPL(label, ante, cons)
`define ITOA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hdl/itoa_pkg.sv]
// types, constants and helpers for the integer to ascii radix unit
// no dependencies
package itoa_pkg;

   // field widths
   localparam int VALUE_BITS = 64;
   localparam int IN_VALUE_W = 64;
   localparam int RADIX_W    = 6;
   localparam int CHAR_W     = 8;
   localparam int DIGIT_W    = RADIX_W;

   // radix limits and characters
   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0]  CHAR_A     = 8'h61;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2d;

   // divider: quotient bits retired per cycle and derived sizes
   localparam int BITS_PER_STEP = 8;
   localparam int DIV_STEPS     = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int PAD_W         = DIV_STEPS * BITS_PER_STEP;
   localparam int STEP_W        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam int CNT_W         = $clog2(VALUE_BITS + 1);
   localparam int ADDR_W        = $clog2(VALUE_BITS);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [VALUE_BITS-1:0] mag;
      logic [RADIX_W-1:0]    radix;
      logic                  neg;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SIGN,
      BK_DIVIDE,
      BK_READ,
      BK_EMIT
   } back_state_type;

   // remainder to ascii digit
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] wide;
      wide = CHAR_W'(d);
      if (d < DIGIT_W'(10)) begin
         return CHAR_ZERO + wide;
      end
      return CHAR_A + wide - CHAR_W'(10);
   endfunction

endpackage

[hdl/itoa_if.sv]
// valid/ready channel interfaces for number requests and character responses
// depends on itoa_pkg
interface itoa_req_if;
   import itoa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [IN_VALUE_W-1:0] value;
   logic [RADIX_W-1:0]    radix;
   logic                  mode;

   modport source (output valid, output value, output radix, output mode, input ready);
   modport sink   (input valid, input value, input radix, input mode, output ready);
endinterface

interface itoa_rsp_if;
   import itoa_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

[hdl/itoa_queue.sv]
// two-entry queue of classified items between front and back
// depends on itoa_pkg
module itoa_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  itoa_pkg::queue_entry_type  push_entry,
   input  logic                       pop,
   output itoa_pkg::queue_entry_type  head,
   output itoa_pkg::queue_status_type status
);
   import itoa_pkg::*;

   queue_entry_type         slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   logic                    do_push, do_pop;

   // status and handshake qualification
   always_comb begin
      status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      head         = slots_ff[rd_ptr_ff];
   end

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[hdl/itoa_front.sv]
// front end: accepts items, clamps the radix, resolves sign and magnitude
// depends on itoa_pkg and itoa_if
module itoa_front (
   itoa_req_if.sink                   req_if,
   input  itoa_pkg::queue_status_type status,
   output logic                       push,
   output itoa_pkg::queue_entry_type  push_entry
);
   import itoa_pkg::*;

   logic [VALUE_BITS-1:0] value_low;
   logic [RADIX_W-1:0]    radix_clamped;
   logic                  negative;

   // classify the incoming item
   always_comb begin
      value_low = req_if.value[VALUE_BITS-1:0];
      if (req_if.radix < RADIX_MIN) begin
         radix_clamped = RADIX_MIN;
      end else if (req_if.radix > RADIX_MAX) begin
         radix_clamped = RADIX_MAX;
      end else begin
         radix_clamped = req_if.radix;
      end
      negative = req_if.mode && (radix_clamped == RADIX_DEC) && value_low[VALUE_BITS-1];
   end

   // build queue entry, two's complement negate wraps for the minimum value
   always_comb begin
      push_entry.mag   = negative ? (~value_low + 1'b1) : value_low;
      push_entry.radix = radix_clamped;
      push_entry.neg   = negative;
      push             = req_if.valid;
      req_if.ready     = !status.full;
   end

endmodule

[hdl/itoa_back.sv]
// back end: digit divider, digit stack memory and character output register
// depends on itoa_pkg, itoa_if and the assertion macro header
`include "integer_to_ascii_radix_unit_defines.svh"
module itoa_back (
   input  logic                       clock,
   input  logic                       reset,
   input  itoa_pkg::queue_entry_type  head,
   input  itoa_pkg::queue_status_type status,
   output logic                       pop,
   itoa_rsp_if.source                 rsp_if
);
   import itoa_pkg::*;

   back_state_type        state_ff, state_in;
   logic [PAD_W-1:0]      quo_ff, quo_in;
   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic [RADIX_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]     char_ff, char_in;
   logic                  last_ff, last_in;

   logic [DIGIT_W-1:0]    digit_mem [VALUE_BITS];
   logic [DIGIT_W-1:0]    rd_data_ff;
   logic [ADDR_W-1:0]     wr_addr, rd_addr;
   logic                  wr_en;

   logic [PAD_W-1:0]      div_quo;
   logic [RADIX_W-1:0]    div_rem;
   logic                  step_done;
   logic                  quo_zero;
   logic                  slot_free;
   logic                  last_digit;

   // one step of restoring division, BITS_PER_STEP quotient bits per cycle
   always_comb begin
      logic [PAD_W-1:0]   work_q;
      logic [RADIX_W:0]   trial;
      logic [RADIX_W-1:0] work_r;
      work_q = quo_ff;
      work_r = rem_ff;
      for (int i = 0; i < BITS_PER_STEP; i++) begin
         trial  = {work_r, work_q[PAD_W-1]};
         work_q = {work_q[PAD_W-2:0], 1'b0};
         if (trial >= {1'b0, radix_ff}) begin
            trial     = trial - {1'b0, radix_ff};
            work_q[0] = 1'b1;
         end
         work_r = trial[RADIX_W-1:0];
      end
      div_quo = work_q;
      div_rem = work_r;
   end

   // shared status terms
   always_comb begin
      step_done  = (step_ff == STEP_W'(DIV_STEPS - 1));
      quo_zero   = (div_quo == '0);
      slot_free  = !out_valid_ff || rsp_if.ready;
      last_digit = (cnt_ff == CNT_W'(1));
      wr_addr    = cnt_ff[ADDR_W-1:0];
      rd_addr    = ADDR_W'(cnt_ff - 1'b1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!status.empty) begin
               state_in = head.neg ? BK_SIGN : BK_DIVIDE;
            end
         end
         BK_SIGN: begin
            if (slot_free) begin
               state_in = BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            if (step_done && quo_zero) begin
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (slot_free) begin
               state_in = last_digit ? BK_IDLE : BK_READ;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // datapath and output register controls
   always_comb begin
      pop          = 1'b0;
      wr_en        = 1'b0;
      quo_in       = quo_ff;
      radix_in     = radix_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!status.empty) begin
               pop      = 1'b1;
               quo_in   = PAD_W'(head.mag);
               radix_in = head.radix;
               rem_in   = '0;
               step_in  = '0;
               cnt_in   = '0;
            end
         end
         BK_SIGN: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               char_in      = CHAR_MINUS;
               last_in      = 1'b0;
            end
         end
         BK_DIVIDE: begin
            quo_in  = div_quo;
            rem_in  = div_rem;
            step_in = step_ff + 1'b1;
            if (step_done) begin
               wr_en   = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
               rem_in  = '0;
               step_in = '0;
            end
         end
         BK_READ: begin
         end
         BK_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               char_in      = digit_char(rd_data_ff);
               last_in      = last_digit;
               cnt_in       = cnt_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      radix_ff <= radix_in;
      rem_ff   <= rem_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   // digit stack, least significant digit at address zero
   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_mem[wr_addr] <= div_rem;
      end
      rd_data_ff <= digit_mem[rd_addr];
   end

   always_comb begin
      rsp_if.valid     = out_valid_ff;
      rsp_if.character = char_ff;
      rsp_if.last      = last_ff;
   end

   // checks
   `ITOA_ASSERT_IMPL(a_rem_below_radix, state_ff == BK_DIVIDE, rem_ff < radix_ff)
   `ITOA_ASSERT_IMPL(a_radix_in_range, state_ff == BK_DIVIDE, radix_ff >= RADIX_MIN && radix_ff <= RADIX_MAX)
   `ITOA_ASSERT_IMPL(a_digit_count_bound, 1'b1, cnt_ff <= CNT_W'(VALUE_BITS))
   `ITOA_ASSERT_IMPL(a_emit_has_digits, state_ff == BK_READ || state_ff == BK_EMIT, cnt_ff != '0)

endmodule

[hdl/integer_to_ascii_radix_unit.sv]
// Integer to ASCII conversion in radix 2 to 36.
//
// req_if carries one number per item: value, radix and mode. A radix below
// 2 acts as 2 and one above 36 acts as 36. With mode set and radix 10 a
// negative value produces a leading '-' followed by its magnitude.
// rsp_if carries one ASCII character per item, most significant digit first,
// with last set on the final character of each number.
// The front end classifies an item in the cycle it is taken and puts it in a
// two-entry queue, so up to two numbers are accepted while one is printing.
// The back end divides by the radix retiring 8 quotient bits per cycle,
// writes each digit to a stack memory, then sends each character through a
// registered memory read and then the output register.
// A stalled receiver holds the output register; the back end waits on it,
// and the queue fills before req_if.ready drops.
// Reset (synchronous, active high) empties the queue and output register.
// depends on itoa_pkg, itoa_if, itoa_front, itoa_queue and itoa_back
module integer_to_ascii_radix_unit (
   input  logic       clock,
   input  logic       reset,
   itoa_req_if.sink   req_if,
   itoa_rsp_if.source rsp_if
);
   import itoa_pkg::*;

   logic             push;
   logic             pop;
   queue_entry_type  push_entry;
   queue_entry_type  head;
   queue_status_type status;

   // accept and classify
   itoa_front u_front (
      .req_if     (req_if),
      .status     (status),
      .push       (push),
      .push_entry (push_entry)
   );

   // decoupling queue
   itoa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   // digit generation and output
   itoa_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .status (status),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule
